FILE: hw/rtl/bed_pkg.sv
// Shared constants, codes and types for the brake event detector.
package bed_pkg;

  localparam int WINDOW_TAPS_DEF = 5;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int EMA_FRAC = 16;
  localparam int CFG_BITS = 16;
  localparam int TIME_BITS = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int STATE_BITS = 2;

  localparam logic [STATE_BITS-1:0] ST_IDLE = 2'd0;
  localparam logic [STATE_BITS-1:0] ST_PENDING = 2'd1;
  localparam logic [STATE_BITS-1:0] ST_BRAKING = 2'd2;
  localparam logic [STATE_BITS-1:0] ST_RELEASING = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_ON = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_OFF = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTH_WEIGHT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONFIRM_MS = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_MS = 3'd4;

  localparam logic [CFG_BITS-1:0] THRESHOLD_ON_RST = 16'hFECD;
  localparam logic [CFG_BITS-1:0] THRESHOLD_OFF_RST = 16'hFFB3;
  localparam logic [CFG_BITS-1:0] SMOOTH_WEIGHT_RST = 16'd9830;
  localparam logic [CFG_BITS-1:0] CONFIRM_MS_RST = 16'd150;
  localparam logic [CFG_BITS-1:0] DEBOUNCE_MS_RST = 16'd50;

  typedef struct packed {
    logic [CFG_BITS-1:0] threshold_on;
    logic [CFG_BITS-1:0] threshold_off;
    logic [CFG_BITS-1:0] smooth_weight;
    logic [CFG_BITS-1:0] confirm_ms;
    logic [CFG_BITS-1:0] debounce_ms;
  } cfg_t;

endpackage

FILE: hw/rtl/brake_event_detector.sv
// Top level of the brake event detector: configuration registers and pipeline control.
//
// Input transactions carry a signed acceleration sample and a millisecond
// timestamp on accel_sample and time_ms, taken when in_valid is high and
// in_stall is low. Every input transaction yields exactly one output
// transaction carrying the filtered value, the brake state and its flags.
// The path has three register stages: the sorted window row, the moving
// average and the state machine with the output register, and a result
// passes through them in that order. One transaction per cycle is
// sustained while out_stall is low; the moving-average update loop sets
// that figure.
// When the receiver holds out_stall, the result stays on the outputs and
// the stages behind it keep filling until each holds a transaction; only
// then does in_stall rise. Configuration registers are written through cfg_write,
// cfg_index and cfg_data while the block is idle, a rule for the user that the
// block does not enforce. An index past the last register is ignored. Synchronous
// reset clears the window to zeros, unseeds the average, returns the state machine
// to idle and loads the default thresholds, weight and times.
module brake_event_detector #(
  parameter int WINDOW_TAPS = bed_pkg::WINDOW_TAPS_DEF,
  parameter int SAMPLE_BITS = bed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bed_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bed_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        accel_sample,
  input  logic [bed_pkg::TIME_BITS-1:0]        time_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        filtered_accel,
  output logic [bed_pkg::STATE_BITS-1:0]       brake_state,
  output logic                                 is_braking,
  output logic                                 is_pending,
  output logic                                 light_on
);

  bed_pkg::cfg_t cfg;

  logic                              v1;
  logic                              v2;
  logic [bed_pkg::TIME_BITS-1:0]     t1;
  logic [bed_pkg::TIME_BITS-1:0]     t2;
  logic                              ready1;
  logic                              ready2;
  logic                              ready3;
  logic                              take1;
  logic                              take2;
  logic                              take3;
  logic signed [SAMPLE_BITS-1:0]     median;
  logic signed [SAMPLE_BITS-1:0]     filt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_on <= bed_pkg::THRESHOLD_ON_RST;
      cfg.threshold_off <= bed_pkg::THRESHOLD_OFF_RST;
      cfg.smooth_weight <= bed_pkg::SMOOTH_WEIGHT_RST;
      cfg.confirm_ms <= bed_pkg::CONFIRM_MS_RST;
      cfg.debounce_ms <= bed_pkg::DEBOUNCE_MS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bed_pkg::REG_THRESHOLD_ON: cfg.threshold_on <= cfg_data;
        bed_pkg::REG_THRESHOLD_OFF: cfg.threshold_off <= cfg_data;
        bed_pkg::REG_SMOOTH_WEIGHT: cfg.smooth_weight <= cfg_data;
        bed_pkg::REG_CONFIRM_MS: cfg.confirm_ms <= cfg_data;
        bed_pkg::REG_DEBOUNCE_MS: cfg.debounce_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign ready3 = !out_valid || !out_stall;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign take1 = in_valid && ready1;
  assign take2 = v1 && ready2;
  assign take3 = v2 && ready3;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      t1 <= time_ms;
    end
    if (take2) begin
      t2 <= t1;
    end
  end

  bed_sort_chain #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .WINDOW_TAPS(WINDOW_TAPS)
  ) u_chain (
    .clk(clk),
    .rst(rst),
    .shift(take1),
    .x(accel_sample),
    .median(median)
  );

  bed_ema #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ema (
    .clk(clk),
    .rst(rst),
    .load(take2),
    .median(median),
    .alpha(cfg.smooth_weight),
    .filt(filt)
  );

  bed_fsm #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_fsm (
    .clk(clk),
    .rst(rst),
    .load(take3),
    .filt(filt),
    .now(t2),
    .cfg(cfg),
    .filtered_accel(filtered_accel),
    .brake_state(brake_state),
    .is_braking(is_braking),
    .is_pending(is_pending),
    .light_on(light_on)
  );

endmodule

FILE: hw/rtl/bed_sort_cell.sv
// One cell of the sorted running window: holds a sample and its age.
module bed_sort_cell #(
  parameter int SAMPLE_BITS = bed_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_TAPS = bed_pkg::WINDOW_TAPS_DEF,
  parameter int IDX = 0,
  localparam int AW = $clog2(WINDOW_TAPS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic                          gone_in,
  input  logic signed [SAMPLE_BITS-1:0] left_val,
  input  logic [AW-1:0]                 left_age,
  input  logic                          left_lt,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  input  logic [AW-1:0]                 right_age,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic [AW-1:0]                 age,
  output logic                          gone_out,
  output logic signed [SAMPLE_BITS-1:0] t_val,
  output logic [AW-1:0]                 t_age,
  output logic                          t_lt
);

  localparam logic [AW-1:0] OLDEST = AW'(WINDOW_TAPS - 1);
  localparam logic [AW-1:0] AGE_RST = AW'(IDX);
  localparam bit FIRST = (IDX == 0);
  localparam bit LAST = (IDX == WINDOW_TAPS - 1);

  logic signed [SAMPLE_BITS-1:0] val_next;
  logic [AW-1:0]                 age_next;

  // The oldest entry drops out and the cells to its right close the gap.
  assign gone_out = gone_in || (age == OLDEST);
  assign t_val = gone_out ? right_val : val;
  assign t_age = gone_out ? right_age : age;
  assign t_lt = !LAST && (t_val < x);

  always_comb begin
    if (t_lt) begin
      val_next = t_val;
      age_next = t_age + AW'(1);
    end else if (FIRST || left_lt) begin
      val_next = x;
      age_next = '0;
    end else begin
      val_next = left_val;
      age_next = left_age + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
      age <= AGE_RST;
    end else if (shift) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

FILE: hw/rtl/bed_sort_chain.sv
// Row of sort cells that keeps the window in order and yields its median.
module bed_sort_chain #(
  parameter int SAMPLE_BITS = bed_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_TAPS = bed_pkg::WINDOW_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic signed [SAMPLE_BITS-1:0] x,
  output logic signed [SAMPLE_BITS-1:0] median
);

  localparam int AW = $clog2(WINDOW_TAPS);

  logic signed [SAMPLE_BITS-1:0] val [WINDOW_TAPS];
  logic [AW-1:0]                 age [WINDOW_TAPS];
  logic                          gone [WINDOW_TAPS];
  logic signed [SAMPLE_BITS-1:0] t_val [WINDOW_TAPS];
  logic [AW-1:0]                 t_age [WINDOW_TAPS];
  logic                          t_lt [WINDOW_TAPS];

  assign gone[0] = 1'b0;
  assign median = val[WINDOW_TAPS / 2];

  for (genvar i = 0; i < WINDOW_TAPS; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lv;
    logic [AW-1:0]                 la;
    logic                          ll;
    logic signed [SAMPLE_BITS-1:0] rv;
    logic [AW-1:0]                 ra;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign la = '0;
      assign ll = 1'b0;
    end else begin : g_inner_left
      assign lv = t_val[i-1];
      assign la = t_age[i-1];
      assign ll = t_lt[i-1];
    end

    if (i == WINDOW_TAPS - 1) begin : g_last
      assign rv = '0;
      assign ra = '0;
      bed_sort_cell #(
        .SAMPLE_BITS(SAMPLE_BITS), .WINDOW_TAPS(WINDOW_TAPS), .IDX(i)
      ) u_cell (
        .clk(clk), .rst(rst), .shift(shift), .x(x), .gone_in(gone[i]),
        .left_val(lv), .left_age(la), .left_lt(ll),
        .right_val(rv), .right_age(ra),
        .val(val[i]), .age(age[i]), .gone_out(),
        .t_val(t_val[i]), .t_age(t_age[i]), .t_lt(t_lt[i])
      );
    end else begin : g_inner
      assign rv = val[i+1];
      assign ra = age[i+1];
      bed_sort_cell #(
        .SAMPLE_BITS(SAMPLE_BITS), .WINDOW_TAPS(WINDOW_TAPS), .IDX(i)
      ) u_cell (
        .clk(clk), .rst(rst), .shift(shift), .x(x), .gone_in(gone[i]),
        .left_val(lv), .left_age(la), .left_lt(ll),
        .right_val(rv), .right_age(ra),
        .val(val[i]), .age(age[i]), .gone_out(gone[i+1]),
        .t_val(t_val[i]), .t_age(t_age[i]), .t_lt(t_lt[i])
      );
    end
  end

endmodule

FILE: hw/rtl/bed_ema.sv
// Exponential moving average of the median with sixteen extra fraction bits.
module bed_ema #(
  parameter int SAMPLE_BITS = bed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic signed [SAMPLE_BITS-1:0]      median,
  input  logic [bed_pkg::CFG_BITS-1:0]       alpha,
  output logic signed [SAMPLE_BITS-1:0]      filt
);

  localparam int AB = SAMPLE_BITS + bed_pkg::EMA_FRAC;
  localparam int DB = AB + 1;
  localparam int PB = DB + bed_pkg::CFG_BITS + 1;

  logic signed [AB-1:0]                 acc;
  logic signed [AB-1:0]                 acc_next;
  logic                                 seeded;
  logic signed [AB-1:0]                 med_sh;
  logic signed [DB-1:0]                 diff;
  logic signed [bed_pkg::CFG_BITS:0]    alpha_s;
  logic signed [PB-1:0]                 prod;
  logic signed [PB-1:0]                 step;

  assign med_sh = {median, {bed_pkg::EMA_FRAC{1'b0}}};
  assign diff = DB'(med_sh) - DB'(acc);
  assign alpha_s = {1'b0, alpha};
  assign prod = PB'(diff) * PB'(alpha_s);
  assign step = prod >>> bed_pkg::EMA_FRAC;
  assign acc_next = seeded ? (acc + $signed(step[AB-1:0])) : med_sh;
  assign filt = acc[AB-1:bed_pkg::EMA_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      seeded <= 1'b0;
    end else if (load) begin
      acc <= acc_next;
      seeded <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/bed_fsm.sv
// Hysteresis state machine with confirm and release timing, and result register.
module bed_fsm #(
  parameter int SAMPLE_BITS = bed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic signed [SAMPLE_BITS-1:0]       filt,
  input  logic [bed_pkg::TIME_BITS-1:0]       now,
  input  bed_pkg::cfg_t                       cfg,
  output logic signed [SAMPLE_BITS-1:0]       filtered_accel,
  output logic [bed_pkg::STATE_BITS-1:0]      brake_state,
  output logic                                is_braking,
  output logic                                is_pending,
  output logic                                light_on
);

  localparam int CW = (SAMPLE_BITS > bed_pkg::CFG_BITS) ? SAMPLE_BITS : bed_pkg::CFG_BITS;

  logic [bed_pkg::STATE_BITS-1:0] state;
  logic [bed_pkg::STATE_BITS-1:0] state_next;
  logic [bed_pkg::TIME_BITS-1:0]  entry_time;
  logic [bed_pkg::TIME_BITS-1:0]  entry_time_next;
  logic [bed_pkg::TIME_BITS-1:0]  elapsed;
  logic signed [CW-1:0]           filt_x;
  logic signed [CW-1:0]           on_x;
  logic signed [CW-1:0]           off_x;
  logic                           below_on;
  logic                           above_off;
  logic                           confirmed;
  logic                           debounced;

  assign filt_x = CW'(filt);
  assign on_x = CW'($signed(cfg.threshold_on));
  assign off_x = CW'($signed(cfg.threshold_off));
  assign below_on = filt_x < on_x;
  assign above_off = filt_x > off_x;
  assign elapsed = now - entry_time;
  assign confirmed = elapsed >= bed_pkg::TIME_BITS'(cfg.confirm_ms);
  assign debounced = elapsed >= bed_pkg::TIME_BITS'(cfg.debounce_ms);

  always_comb begin
    state_next = state;
    entry_time_next = entry_time;
    unique case (state)
      bed_pkg::ST_IDLE: begin
        if (below_on) begin
          state_next = bed_pkg::ST_PENDING;
          entry_time_next = now;
        end
      end
      bed_pkg::ST_PENDING: begin
        if (above_off) begin
          state_next = bed_pkg::ST_IDLE;
        end else if (confirmed) begin
          state_next = bed_pkg::ST_BRAKING;
        end
      end
      bed_pkg::ST_BRAKING: begin
        if (above_off) begin
          state_next = bed_pkg::ST_RELEASING;
          entry_time_next = now;
        end
      end
      default: begin
        if (below_on) begin
          state_next = bed_pkg::ST_BRAKING;
        end else if (debounced) begin
          state_next = bed_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bed_pkg::ST_IDLE;
      entry_time <= '0;
    end else if (load) begin
      state <= state_next;
      entry_time <= entry_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      filtered_accel <= filt;
    end
  end

  assign brake_state = state;
  assign is_braking = (state == bed_pkg::ST_BRAKING);
  assign is_pending = (state == bed_pkg::ST_PENDING);
  assign light_on = (state != bed_pkg::ST_IDLE);

endmodule
